// ===== design/assert_macros.svh =====
// Assertion macros shared by the RTL of this project.
// Include from any module that carries concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define ASSERT_AT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Condition must never be seen outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define ASSERT_AT(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

// ===== design/ou_psu_pkg.sv =====
// Shared types, constants and tables for the OU series update block.
// No dependencies; used by ou_psu_ctrl, ou_psu_dp and the top level.
`timescale 1ns / 1ps
package ou_psu_pkg;

    localparam int DATA_W = 32;
    localparam int FRAC_W = 16;
    localparam int IBITS  = 30;
    localparam int ACC_W  = 36;
    localparam int PROD_W = 64;
    localparam int SQ_W   = 63;

    localparam logic [30:0] ONE_I  = 31'h4000_0000;
    localparam logic [21:0] X_CAP  = 22'h20_0000;
    localparam logic [33:0] N_CAP  = 34'h2_0000_0000;

    // Configuration register indexes
    localparam logic [1:0] REG_MEAN  = 2'd0;
    localparam logic [1:0] REG_SCALE = 2'd1;
    localparam logic [1:0] REG_INV   = 2'd2;

    // Multiply operations of the shared multiplier
    typedef enum logic [3:0] {
        MOP_NONE,
        MOP_X,
        MOP_TR,
        MOP_TDIV,
        MOP_DP,
        MOP_PP,
        MOP_DD,
        MOP_MD,
        MOP_S1,
        MOP_TERM,
        MOP_STERM
    } mop_t;

    typedef struct packed {
        logic       load;
        mop_t       mop;
        logic       wb;
        logic       exp_init;
        logic       exp_sel;
        logic       save_d;
        logic       save_p;
        logic       sq_init;
        logic       sq_step;
        logic       finish;
        logic [3:0] div_idx;
    } cmd_t;

    typedef struct packed {
        logic [4:0] whole;
    } stat_t;

    typedef enum logic [14:0] {
        ST_IDLE     = 15'h0001,
        ST_XMUL     = 15'h0002,
        ST_EXP_INIT = 15'h0004,
        ST_TR       = 15'h0008,
        ST_TDIV     = 15'h0010,
        ST_EXP_DONE = 15'h0020,
        ST_DP       = 15'h0040,
        ST_PP       = 15'h0080,
        ST_DD       = 15'h0100,
        ST_SQ_INIT  = 15'h0200,
        ST_SQRT     = 15'h0400,
        ST_MD       = 15'h0800,
        ST_S1       = 15'h1000,
        ST_TERM     = 15'h2000,
        ST_DONE     = 15'h4000
    } state_t;

    // Exact floor(n / (k+1)) for n < 2^31 as (n * m) >> sh
    function automatic logic [31:0] div_mult(input logic [3:0] k);
        logic [31:0] m;
        case (k)
            4'd0:    m = 32'd2147483648;
            4'd1:    m = 32'd2147483648;
            4'd2:    m = 32'd2863311531;
            4'd3:    m = 32'd2147483648;
            4'd4:    m = 32'd3435973837;
            4'd5:    m = 32'd2863311531;
            4'd6:    m = 32'd2454267027;
            4'd7:    m = 32'd2147483648;
            4'd8:    m = 32'd3817748708;
            4'd9:    m = 32'd3435973837;
            4'd10:   m = 32'd3123612579;
            4'd11:   m = 32'd2863311531;
            4'd12:   m = 32'd2643056798;
            4'd13:   m = 32'd2454267027;
            4'd14:   m = 32'd2290649225;
            default: m = 32'd2147483648;
        endcase
        return m;
    endfunction

    function automatic logic [5:0] div_shift(input logic [3:0] k);
        logic [5:0] s;
        case (k)
            4'd0:                      s = 6'd31;
            4'd1:                      s = 6'd32;
            4'd2, 4'd3:                s = 6'd33;
            4'd4, 4'd5, 4'd6, 4'd7:    s = 6'd34;
            default:                   s = 6'd35;
        endcase
        return s;
    endfunction

endpackage

// ===== design/ou_psu_ctrl.sv =====
// Sequencer of the OU series update: walks one item through the datapath.
// Depends on ou_psu_pkg for command, status and state types.
`timescale 1ns / 1ps
module ou_psu_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic               start_in,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  ou_psu_pkg::stat_t  stat,
    output ou_psu_pkg::cmd_t   cmd
);

    ou_psu_pkg::state_t state_reg, state_next;
    logic       phase_reg, phase_next;
    logic [3:0] idx_reg, idx_next;
    logic [2:0] bit_reg, bit_next;
    logic [4:0] sq_cnt_reg, sq_cnt_next;
    logic       exp_sel_reg, exp_sel_next;
    logic       start_reg, start_next;
    logic       out_valid_reg, out_valid_next;

    // State and counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ou_psu_pkg::ST_IDLE;
            phase_reg     <= 1'b0;
            idx_reg       <= '0;
            bit_reg       <= '0;
            sq_cnt_reg    <= '0;
            exp_sel_reg   <= 1'b0;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            idx_reg       <= idx_next;
            bit_reg       <= bit_next;
            sq_cnt_reg    <= sq_cnt_next;
            exp_sel_reg   <= exp_sel_next;
            start_reg     <= start_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == ou_psu_pkg::ST_IDLE);
    assign m_tvalid = out_valid_reg;

    // Next state and commands; each multiply state runs issue then writeback
    always_comb begin
        state_next   = state_reg;
        phase_next   = 1'b0;
        idx_next     = idx_reg;
        bit_next     = bit_reg;
        sq_cnt_next  = sq_cnt_reg;
        exp_sel_next = exp_sel_reg;
        start_next   = start_reg;
        cmd          = '0;
        cmd.mop      = ou_psu_pkg::MOP_NONE;
        cmd.div_idx  = idx_reg;
        cmd.exp_sel  = exp_sel_reg;
        unique case (state_reg)
            ou_psu_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    start_next = start_in;
                    state_next = start_in ? ou_psu_pkg::ST_TERM : ou_psu_pkg::ST_XMUL;
                end
            end
            ou_psu_pkg::ST_XMUL: begin
                cmd.mop    = ou_psu_pkg::MOP_X;
                cmd.wb     = phase_reg;
                phase_next = !phase_reg;
                if (phase_reg) begin
                    exp_sel_next = 1'b0;
                    state_next   = ou_psu_pkg::ST_EXP_INIT;
                end
            end
            ou_psu_pkg::ST_EXP_INIT: begin
                cmd.exp_init = 1'b1;
                idx_next     = '0;
                state_next   = ou_psu_pkg::ST_TR;
            end
            ou_psu_pkg::ST_TR: begin
                cmd.mop    = ou_psu_pkg::MOP_TR;
                cmd.wb     = phase_reg;
                phase_next = !phase_reg;
                if (phase_reg) state_next = ou_psu_pkg::ST_TDIV;
            end
            ou_psu_pkg::ST_TDIV: begin
                cmd.mop    = ou_psu_pkg::MOP_TDIV;
                cmd.wb     = phase_reg;
                phase_next = !phase_reg;
                if (phase_reg) begin
                    if (idx_reg == 4'd15) begin
                        state_next = ou_psu_pkg::ST_EXP_DONE;
                    end else begin
                        idx_next   = idx_reg + 4'd1;
                        state_next = ou_psu_pkg::ST_TR;
                    end
                end
            end
            ou_psu_pkg::ST_EXP_DONE: begin
                if (!exp_sel_reg) begin
                    cmd.save_d   = 1'b1;
                    exp_sel_next = 1'b1;
                    state_next   = ou_psu_pkg::ST_EXP_INIT;
                end else begin
                    cmd.save_p = 1'b1;
                    bit_next   = '0;
                    state_next = ou_psu_pkg::ST_DP;
                end
            end
            ou_psu_pkg::ST_DP: begin
                // multiply in exp(-2^b) only where that bit of the integer part is set
                if (stat.whole[bit_reg]) begin
                    cmd.mop    = ou_psu_pkg::MOP_DP;
                    cmd.wb     = phase_reg;
                    phase_next = !phase_reg;
                    if (phase_reg) state_next = ou_psu_pkg::ST_PP;
                end else begin
                    state_next = ou_psu_pkg::ST_PP;
                end
            end
            ou_psu_pkg::ST_PP: begin
                cmd.mop    = ou_psu_pkg::MOP_PP;
                cmd.wb     = phase_reg;
                phase_next = !phase_reg;
                if (phase_reg) begin
                    if (bit_reg == 3'd4) begin
                        state_next = ou_psu_pkg::ST_DD;
                    end else begin
                        bit_next   = bit_reg + 3'd1;
                        state_next = ou_psu_pkg::ST_DP;
                    end
                end
            end
            ou_psu_pkg::ST_DD: begin
                cmd.mop    = ou_psu_pkg::MOP_DD;
                cmd.wb     = phase_reg;
                phase_next = !phase_reg;
                if (phase_reg) state_next = ou_psu_pkg::ST_SQ_INIT;
            end
            ou_psu_pkg::ST_SQ_INIT: begin
                cmd.sq_init = 1'b1;
                sq_cnt_next = '0;
                state_next  = ou_psu_pkg::ST_SQRT;
            end
            ou_psu_pkg::ST_SQRT: begin
                cmd.sq_step = 1'b1;
                sq_cnt_next = sq_cnt_reg + 5'd1;
                if (sq_cnt_reg == 5'd31) state_next = ou_psu_pkg::ST_MD;
            end
            ou_psu_pkg::ST_MD: begin
                cmd.mop    = ou_psu_pkg::MOP_MD;
                cmd.wb     = phase_reg;
                phase_next = !phase_reg;
                if (phase_reg) state_next = ou_psu_pkg::ST_S1;
            end
            ou_psu_pkg::ST_S1: begin
                cmd.mop    = ou_psu_pkg::MOP_S1;
                cmd.wb     = phase_reg;
                phase_next = !phase_reg;
                if (phase_reg) state_next = ou_psu_pkg::ST_TERM;
            end
            ou_psu_pkg::ST_TERM: begin
                cmd.mop    = start_reg ? ou_psu_pkg::MOP_STERM : ou_psu_pkg::MOP_TERM;
                cmd.wb     = phase_reg;
                phase_next = !phase_reg;
                if (phase_reg) state_next = ou_psu_pkg::ST_DONE;
            end
            ou_psu_pkg::ST_DONE: begin
                // wait until the output register is free
                if (!out_valid_reg || m_tready) begin
                    cmd.finish = 1'b1;
                    state_next = ou_psu_pkg::ST_IDLE;
                end
            end
            default: state_next = ou_psu_pkg::ST_IDLE;
        endcase
    end

    // Output register occupancy
    always_comb begin
        if (cmd.finish)    out_valid_next = 1'b1;
        else if (m_tready) out_valid_next = 1'b0;
        else               out_valid_next = out_valid_reg;
    end

endmodule

// ===== design/ou_psu_dp.sv =====
// Datapath of the OU series update: config registers, state, shared multiplier,
// square root iteration and accumulator. Depends on ou_psu_pkg.
`timescale 1ns / 1ps
module ou_psu_dp (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic [31:0]        in_time,
    input  logic [31:0]        in_noise,
    input  ou_psu_pkg::cmd_t   cmd,
    output ou_psu_pkg::stat_t  stat,
    output logic [31:0]        value
);

    logic [31:0] mean_reg, scale_reg, inv_reg;
    logic [31:0] prev_v_reg, prev_t_reg;
    logic [31:0] gap_reg, nmag_reg;
    logic        nneg_reg;
    logic [21:0] x_reg;
    logic [30:0] r_reg, term_reg, rest_reg, sq_reg;
    logic [31:0] sum_reg, d_reg, p_reg, s1_reg;
    logic signed [ou_psu_pkg::ACC_W-1:0] acc_reg;
    logic [ou_psu_pkg::SQ_W-1:0] v_reg, res_reg, bit_reg;
    logic [ou_psu_pkg::PROD_W-1:0] prod_reg;
    logic [31:0] value_reg;

    logic [31:0] mul_a, mul_b;
    logic [5:0]  mul_sh;
    logic [ou_psu_pkg::PROD_W-1:0] mul_cap, shifted, capped;
    logic [33:0] mres;
    logic signed [32:0] diff;
    logic [31:0] diff_mag;
    logic [31:0] sum_odd;
    logic [ou_psu_pkg::SQ_W-1:0] trial;
    logic signed [ou_psu_pkg::ACC_W-1:0] acc_sat_lo, acc_sat_hi;
    logic [31:0] sat_val;

    // Root is final once the trial bit has shifted out
    function automatic logic sq_step_done();
        return (cmd.mop == ou_psu_pkg::MOP_MD) && !cmd.wb;
    endfunction

    assign stat.whole = x_reg[20:16];
    assign value      = value_reg;

    // Configuration and per-series state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mean_reg   <= '0;
            scale_reg  <= 32'h0001_0000;
            inv_reg    <= 32'h0001_0000;
            prev_v_reg <= '0;
            prev_t_reg <= '0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    ou_psu_pkg::REG_MEAN:  mean_reg  <= cfg_data;
                    ou_psu_pkg::REG_SCALE: scale_reg <= cfg_data;
                    ou_psu_pkg::REG_INV:   inv_reg   <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.load)   prev_t_reg <= in_time;
            if (cmd.finish) prev_v_reg <= sat_val;
        end
    end

    // Difference to the mean in sign-magnitude form
    assign diff     = $signed({prev_v_reg[31], prev_v_reg}) - $signed({mean_reg[31], mean_reg});
    assign diff_mag = diff[32] ? 32'(-diff) : diff[31:0];

    // Operand, shift and cap selection
    always_comb begin
        mul_a   = '0;
        mul_b   = '0;
        mul_sh  = 6'd30;
        mul_cap = 64'(ou_psu_pkg::ONE_I);
        case (cmd.mop)
            ou_psu_pkg::MOP_X: begin
                mul_a = gap_reg; mul_b = inv_reg; mul_sh = 6'd16;
                mul_cap = 64'(ou_psu_pkg::X_CAP);
            end
            ou_psu_pkg::MOP_TR: begin
                mul_a = 32'(term_reg); mul_b = 32'(r_reg);
            end
            ou_psu_pkg::MOP_TDIV: begin
                mul_a   = 32'(term_reg);
                mul_b   = ou_psu_pkg::div_mult(cmd.div_idx);
                mul_sh  = ou_psu_pkg::div_shift(cmd.div_idx);
                mul_cap = '1;
            end
            ou_psu_pkg::MOP_DP: begin
                mul_a = d_reg; mul_b = p_reg;
            end
            ou_psu_pkg::MOP_PP: begin
                mul_a = p_reg; mul_b = p_reg;
            end
            ou_psu_pkg::MOP_DD: begin
                mul_a = d_reg; mul_b = d_reg;
            end
            ou_psu_pkg::MOP_MD: begin
                mul_a = diff_mag; mul_b = d_reg;
                mul_cap = 64'(ou_psu_pkg::N_CAP);
            end
            ou_psu_pkg::MOP_S1: begin
                mul_a = scale_reg; mul_b = 32'(sq_reg);
                mul_cap = 64'(32'hFFFF_FFFF);
            end
            ou_psu_pkg::MOP_TERM: begin
                mul_a = s1_reg; mul_b = nmag_reg; mul_sh = 6'd16;
                mul_cap = 64'(ou_psu_pkg::N_CAP);
            end
            ou_psu_pkg::MOP_STERM: begin
                mul_a = scale_reg; mul_b = nmag_reg; mul_sh = 6'd16;
                mul_cap = 64'(ou_psu_pkg::N_CAP);
            end
            default: ;
        endcase
    end

    // Product register; shift and saturate on the writeback cycle
    always_ff @(posedge aclk) begin
        prod_reg <= 64'(mul_a) * 64'(mul_b);
    end

    assign shifted = prod_reg >> mul_sh;
    assign capped  = (shifted > mul_cap) ? mul_cap : shifted;
    assign mres    = capped[33:0];

    // Alternating series: odd terms subtract with floor at zero
    assign sum_odd = (32'(mres[30:0]) > sum_reg) ? 32'd0 : sum_reg - 32'(mres[30:0]);

    // Square root trial value
    assign trial = res_reg + bit_reg;

    // Saturation of the accumulator to the signed 32-bit range
    assign acc_sat_lo = -(ou_psu_pkg::ACC_W'(64'sh8000_0000));
    assign acc_sat_hi = ou_psu_pkg::ACC_W'(64'sh7FFF_FFFF);
    always_comb begin
        if (acc_reg < acc_sat_lo)      sat_val = 32'h8000_0000;
        else if (acc_reg > acc_sat_hi) sat_val = 32'h7FFF_FFFF;
        else                           sat_val = acc_reg[31:0];
    end

    // Working registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            gap_reg  <= (in_time >= prev_t_reg) ? in_time - prev_t_reg : 32'd0;
            nneg_reg <= in_noise[31];
            nmag_reg <= in_noise[31] ? 32'(-in_noise) : in_noise;
            acc_reg  <= ou_psu_pkg::ACC_W'($signed(mean_reg));
        end
        if (cmd.exp_init) begin
            r_reg    <= cmd.exp_sel ? ou_psu_pkg::ONE_I : {1'b0, x_reg[15:0], 14'b0};
            term_reg <= ou_psu_pkg::ONE_I;
            sum_reg  <= 32'(ou_psu_pkg::ONE_I);
        end
        if (cmd.save_d) d_reg <= x_reg[21] ? 32'd0 : sum_reg;
        if (cmd.save_p) p_reg <= sum_reg;
        if (cmd.sq_init) begin
            v_reg   <= {2'b0, rest_reg, 30'b0};
            res_reg <= '0;
            bit_reg <= {1'b1, 62'b0};
        end
        if (cmd.sq_step) begin
            if (v_reg >= trial) begin
                v_reg   <= v_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end else begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
        if (cmd.wb) begin
            case (cmd.mop)
                ou_psu_pkg::MOP_X:  x_reg <= mres[21:0];
                ou_psu_pkg::MOP_TR: term_reg <= mres[30:0];
                ou_psu_pkg::MOP_TDIV: begin
                    term_reg <= mres[30:0];
                    // div_idx even means an odd term number
                    sum_reg  <= cmd.div_idx[0] ? sum_reg + 32'(mres[30:0]) : sum_odd;
                end
                ou_psu_pkg::MOP_DP: d_reg <= mres[31:0];
                ou_psu_pkg::MOP_PP: p_reg <= mres[31:0];
                ou_psu_pkg::MOP_DD: rest_reg <= ou_psu_pkg::ONE_I - mres[30:0];
                ou_psu_pkg::MOP_MD: begin
                    if (diff[32]) acc_reg <= acc_reg - ou_psu_pkg::ACC_W'(mres);
                    else          acc_reg <= acc_reg + ou_psu_pkg::ACC_W'(mres);
                end
                ou_psu_pkg::MOP_S1: s1_reg <= mres[31:0];
                ou_psu_pkg::MOP_TERM, ou_psu_pkg::MOP_STERM: begin
                    if (nneg_reg) acc_reg <= acc_reg - ou_psu_pkg::ACC_W'(mres);
                    else          acc_reg <= acc_reg + ou_psu_pkg::ACC_W'(mres);
                end
                default: ;
            endcase
        end
        if (sq_step_done()) sq_reg <= res_reg[30:0];
        if (cmd.finish) value_reg <= sat_val;
    end

endmodule

// ===== design/ou_process_series_update.sv =====
// Ornstein-Uhlenbeck series update: one value per (time, noise) item, signed
// Q16.16. A series-start item goes straight to the noise term; a continuation
// item is paced by the single shared 32x32 multiplier, which evaluates
// two 16-term exp(-r) series (two products per term), five squarings of
// exp(-1) plus up to five multiplies for the integer part of the exponent,
// and a bit-pair square root. One item is worked at a time; the next item is
// accepted the cycle after a result is loaded, and a finished result waits in
// the output register while the next item is worked. Configuration writes are
// taken every cycle and are meant for idle.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ou_process_series_update (
    input  logic        aclk,
    input  logic        aresetn,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] sample_time, [63:32] noise
    input  logic [0:0]  s_tuser,   // [0] series_start
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] value
    // Configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    ou_psu_pkg::cmd_t  cmd;
    ou_psu_pkg::stat_t stat;

    assign cfg_ready = 1'b1;

    // Sequencer
    ou_psu_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .start_in (s_tuser[0]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Arithmetic
    ou_psu_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_time   (s_tdata[31:0]),
        .in_noise  (s_tdata[63:32]),
        .cmd       (cmd),
        .stat      (stat),
        .value     (m_tdata)
    );

    // Checks
    `ASSERT_NEVER(a_no_overwrite, aclk, aresetn, cmd.finish && m_tvalid && !m_tready, "result overwritten")
    `ASSERT_AT(a_valid_source, aclk, aresetn, $rose(m_tvalid) |-> $past(cmd.finish), "result without finish")
    `ASSERT_NEVER(a_idle_no_wb, aclk, aresetn, s_tready && cmd.wb, "writeback while idle")
    `ASSERT_AT(a_finish_valid, aclk, aresetn, cmd.finish |=> m_tvalid, "finish lost result")

endmodule
